[hw/rtl/bdeq_pkg.sv]
// shared types and constants for the bounded double-ended queue
`default_nettype none

package bdeq_pkg;

  // data and register widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 11;
  localparam int unsigned KindW    = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 72;

  // storage depth default and capacity after reset
  localparam int unsigned DepthDef = 1024;
  localparam logic [CapW-1:0] CapReset = 11'd1024;

  // value reported for front and rear of an empty queue
  localparam logic [DataW-1:0] EmptyValue = '1;

  // operation codes carried on the input tuser
  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_e;

  // which cached end is refreshed from the memory read
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_FRONT,
    UPD_REAR
  } upd_e;

endpackage

`default_nettype wire

[hw/rtl/bounded_double_ended_queue.sv]
// bounded double-ended queue on a ring buffer memory with cached front and rear
//
//  channel   | direction | handshake                  | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser kind, tdata item_value
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata ok, front, rear, empty, full
//  cfg       | in        | cfg_valid_i/cfg_ready_o     | cfg_data_i capacity
//
//  every operation passes through accept and then a read state for the synchronous
//  memory read that refreshes the front or rear after a pop
//  a new operation is taken while the previous result still waits on m_axis;
//  a result that cannot leave parks in a hold state and blocks further input
//  reset empties the queue and sets capacity to 1024; the memory is not cleared
`default_nettype none

module bounded_double_ended_queue
  import bdeq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input item
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [31:0] item_value
  input  wire logic [KindW-1:0]    s_axis_tuser,   // [2:0] kind
  // result item
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [0] ok, [32:1] front_value,
                                                   // [64:33] rear_value, [65] is_empty,
                                                   // [66] is_full, [71:67] zero
  // capacity register write
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CapW-1:0]     cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  // ring index add that wraps at DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  state_e            state_q, state_d;
  upd_e              upd_q, upd_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [DataW-1:0]  front_q, front_d;
  logic [DataW-1:0]  rear_q, rear_d;
  logic              ok_q, ok_d;
  logic [CapW-1:0]   cap_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [DataW-1:0]  entry_mem_q [DEPTH];
  logic [DataW-1:0]  rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;

  logic              in_xfer;
  logic              out_free;
  logic              load_out;
  logic              is_full;
  logic [MW-1:0]     eff_cap;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     rear_wr_idx;
  logic [AW-1:0]     rear_rd_idx;
  logic [CW-1:0]     count_m2;
  logic [DataW-1:0]  in_value;
  kind_e             in_kind;

  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[DataW-1:0];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // effective capacity saturates at DEPTH
  always_comb begin
    if (MW'(cap_q) > MW'(DEPTH)) eff_cap = MW'(DEPTH);
    else                         eff_cap = MW'(cap_q);
  end
  assign is_full = (MW'(count_q) >= eff_cap);

  // ring positions around the occupied span
  assign count_m2    = count_q - CW'(2);
  assign head_dec    = wrap_add(head_q, AW'(DEPTH - 1));
  assign head_inc    = wrap_add(head_q, AW'(1));
  assign rear_wr_idx = wrap_add(head_q, count_q[AW-1:0]);
  assign rear_rd_idx = wrap_add(head_q, count_m2[AW-1:0]);

  // operation decode, state update and memory access on accept
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ok_d      = ok_q;
    upd_d     = upd_q;
    front_d   = front_q;
    rear_d    = rear_q;
    mem_we    = 1'b0;
    mem_waddr = head_dec;
    mem_raddr = head_inc;
    // refresh a cached end from the read issued on accept
    if (state_q == ST_READ) begin
      unique case (upd_q)
        UPD_FRONT: front_d = rd_data_q;
        UPD_REAR:  rear_d  = rd_data_q;
        default:   ;
      endcase
    end
    if (in_xfer) begin
      ok_d  = 1'b0;
      upd_d = UPD_NONE;
      unique case (in_kind)
        KIND_PUSH_FRONT: begin
          if (!is_full) begin
            ok_d      = 1'b1;
            head_d    = head_dec;
            count_d   = count_q + CW'(1);
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            front_d   = in_value;
            if (count_q == '0) rear_d = in_value;
          end
        end
        KIND_PUSH_REAR: begin
          if (!is_full) begin
            ok_d      = 1'b1;
            count_d   = count_q + CW'(1);
            mem_we    = 1'b1;
            mem_waddr = rear_wr_idx;
            rear_d    = in_value;
            if (count_q == '0) front_d = in_value;
          end
        end
        KIND_POP_FRONT: begin
          if (count_q != '0) begin
            ok_d      = 1'b1;
            head_d    = head_inc;
            count_d   = count_q - CW'(1);
            mem_raddr = head_inc;
            if (count_q != CW'(1)) upd_d = UPD_FRONT;
          end
        end
        KIND_POP_REAR: begin
          if (count_q != '0) begin
            ok_d      = 1'b1;
            count_d   = count_q - CW'(1);
            mem_raddr = rear_rd_idx;
            if (count_q != CW'(1)) upd_d = UPD_REAR;
          end
        end
        KIND_QUERY: ok_d = 1'b1;
        default:    ok_d = 1'b0;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_READ;
      ST_READ: state_d = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_READ: load_out      = out_free;
      ST_HOLD: load_out      = out_free;
      default: ;
    endcase
  end

  // control and cached state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upd_q   <= UPD_NONE;
      head_q  <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
      cap_q   <= CapReset;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
      head_q  <= head_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
  end

  // entry storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem_q[mem_waddr] <= in_value;
    rd_data_q <= entry_mem_q[mem_raddr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {5'b0,
                     is_full,
                     (count_q == '0),
                     (count_q == '0) ? EmptyValue : rear_d,
                     (count_q == '0) ? EmptyValue : front_d,
                     ok_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // an accepted transaction always issues its memory read cycle next
  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_READ)
    else $error("no read cycle after accept");

  // a result is only loaded from the read or hold state
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_HOLD))
    else $error("result loaded outside read or hold");

  // empty result reports the empty marker at both ends
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[65]) |->
      (out_data_q[32:1] == EmptyValue && out_data_q[64:33] == EmptyValue))
    else $error("empty result with live end values");

  // a successful pop lowers the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && count_q != '0 &&
     (in_kind == KIND_POP_FRONT || in_kind == KIND_POP_REAR))
      |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not decrement count");

endmodule

`default_nettype wire

[tb/bounded_double_ended_queue_tb.sv]
// self-checking testbench for the bounded double-ended queue
`timescale 1ns / 1ps

module bounded_double_ended_queue_tb
  import bdeq_pkg::*;
;

  localparam int Depth      = DepthDef;
  localparam int HalfPeriod = 6;
  localparam int IdleLimit  = 2000;
  localparam int LongHold   = 300;
  localparam int KindSpan   = 1 << KindW;

  localparam logic [DataW-1:0] MostNeg = 32'h8000_0000;
  localparam logic [DataW-1:0] MostPos = 32'h7fff_ffff;

  // result word as it leaves on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [OutDataW-68:0] pad;
    logic                 is_full;
    logic                 is_empty;
    logic [DataW-1:0]     rear_value;
    logic [DataW-1:0]     front_value;
    logic                 ok;
  } deque_result_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_e;

  // shadow copy of the deque and the results it still owes
  class deque_shadow;
    logic [DataW-1:0] entries [Depth];
    int unsigned      head;
    int unsigned      count;
    int unsigned      capacity;
    deque_result_t    pending [$];
    int               mismatches;

    function new();
      head       = 0;
      count      = 0;
      capacity   = CapReset;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
    endfunction

    function int unsigned usable_capacity();
      return (capacity > Depth) ? Depth : capacity;
    endfunction

    // apply one accepted operation and queue the result it must produce
    function void apply_op(logic [KindW-1:0] kind, logic [DataW-1:0] value);
      deque_result_t res;
      logic          full;
      full = (count >= usable_capacity());
      res  = '0;
      case (kind)
        KIND_PUSH_FRONT: if (!full) begin
          head = (head + Depth - 1) % Depth;
          entries[head] = value;
          count++;
          res.ok = 1'b1;
        end
        KIND_PUSH_REAR: if (!full) begin
          entries[(head + count) % Depth] = value;
          count++;
          res.ok = 1'b1;
        end
        KIND_POP_FRONT: if (count != 0) begin
          head = (head + 1) % Depth;
          count--;
          res.ok = 1'b1;
        end
        KIND_POP_REAR: if (count != 0) begin
          count--;
          res.ok = 1'b1;
        end
        KIND_QUERY: res.ok = 1'b1;
        default: res.ok = 1'b0;
      endcase
      res.front_value = EmptyValue;
      res.rear_value  = EmptyValue;
      if (count != 0) begin
        res.front_value = entries[head];
        res.rear_value  = entries[(head + count - 1) % Depth];
      end
      res.is_empty = (count == 0);
      res.is_full  = (count >= usable_capacity());
      pending.push_back(res);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // compare one result transaction against the oldest pending result
    function void check_result(logic [OutDataW-1:0] word);
      deque_result_t got;
      deque_result_t want;
      got = word;
      if (pending.size() == 0) begin
        mismatches++;
        $error("result %0h arrived with no operation outstanding", word);
        return;
      end
      want = pending.pop_front();
      compare_field("ok", DataW'(want.ok), DataW'(got.ok));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("rear_value", want.rear_value, got.rear_value);
      compare_field("is_empty", DataW'(want.is_empty), DataW'(got.is_empty));
      compare_field("is_full", DataW'(want.is_full), DataW'(got.is_full));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CapW-1:0]     cfg_data_i    = '0;

  deque_shadow shadow;
  int          idle_cycles = 0;
  int          hold_asks   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          style_left  = 0;
  rx_style_e   rx_style    = RX_STEADY;

  bounded_double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // monitor: check results, note operations and capacity writes, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        shadow.check_result(m_axis_tdata);
        idle_cycles = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        shadow.apply_op(s_axis_tuser, s_axis_tdata);
        idle_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow.set_capacity(cfg_data_i);
        idle_cycles = 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("bounded_double_ended_queue_tb NOT OK");
        $finish;
      end
    end
  end

  // receiver: changing stall styles plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
    end
    if (style_left == 0) begin
      rx_style   = rx_style_e'($urandom_range(RX_STEADY, RX_SPARSE));
      style_left = $urandom_range(10, 80);
    end else begin
      style_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_STEADY:  m_axis_tready <= 1'b1;
        RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_axis_tready <= (style_left % 4) != 0;
        default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one operation and hold it until the transaction completes
  task automatic offer(logic [KindW-1:0] kind, logic [DataW-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop offering until every outstanding result has been taken
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending.size() != 0) @(posedge clk_i);
  endtask

  // capacity is only changed with the block drained
  task automatic write_capacity(logic [CapW-1:0] value);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return MostNeg;
      1:       return MostPos;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // push share in percent, pops take most of the rest
  function automatic logic [KindW-1:0] pick_kind(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
    if (roll < push_pct + (100 - push_pct) * 4 / 5)
      return $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
    if ($urandom_range(0, 1))
      return KIND_QUERY;
    return KindW'($urandom_range(KIND_QUERY + 1, KindSpan - 1));
  endfunction

  // random bursts with gaps; optionally start a long receiver hold-off
  task automatic run_phase(int items, int push_pct, bit with_hold);
    int left;
    int burst;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        offer(pick_kind(push_pct), pick_value());
        left--;
        if (with_hold && left == items - 30) hold_asks++;
      end
      case ($urandom_range(0, 19))
        0:             wait_idle();
        1, 2, 3, 4, 5: ;
        default:       pause_sender($urandom_range(1, 10));
      endcase
    end
  endtask

  initial begin
    shadow = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, refused pops and unused kinds at reset capacity
    offer(KIND_QUERY, pick_value());
    offer(KIND_POP_FRONT, pick_value());
    offer(KIND_POP_REAR, pick_value());
    for (int k = KIND_QUERY + 1; k < KindSpan; k++) offer(KindW'(k), MostPos);
    // extreme values at both ends, then drain past empty
    offer(KIND_PUSH_FRONT, MostNeg);
    offer(KIND_PUSH_REAR, MostPos);
    offer(KIND_PUSH_FRONT, '1);
    offer(KIND_PUSH_REAR, '0);
    offer(KIND_QUERY, '0);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_POP_REAR, '0);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_POP_REAR, '0);
    offer(KIND_POP_FRONT, '0);

    // zero capacity: empty and full at once, pushes refused
    write_capacity('0);
    offer(KIND_PUSH_FRONT, MostPos);
    offer(KIND_PUSH_REAR, MostNeg);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_QUERY, '0);

    // capacity of one
    write_capacity(CapW'(1));
    offer(KIND_PUSH_REAR, 32'h1234_5678);
    offer(KIND_PUSH_FRONT, 32'hdead_beef);
    offer(KIND_QUERY, '0);
    offer(KIND_POP_FRONT, '0);
    offer(KIND_POP_REAR, '0);

    // random phases over several capacities
    write_capacity(CapW'(5));
    run_phase(200, 50, 1'b0);
    write_capacity(CapW'(2));
    run_phase(100, 50, 1'b0);
    write_capacity(CapW'(37));
    run_phase(120, 55, 1'b0);
    // above depth: saturates, fills the whole ring and wraps
    write_capacity('1);
    run_phase(1180, 96, 1'b1);
    // capacity far below the count: pushes refused, pops go on
    write_capacity(CapW'(9));
    run_phase(150, 10, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
      $display("bounded_double_ended_queue_tb OK");
    end else begin
      $display("bounded_double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bdeq_pkg.sv
hw/rtl/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_tb.sv
